[hw/rtl/hsv2rgb_pkg.sv]
// shared constants and types for the hsv to rgb converter
package hsv2rgb_pkg;

   localparam logic [12:0] HUE_LIMIT   = 13'd5760;
   localparam logic [12:0] SECTOR_SPAN = 13'd960;
   localparam logic [15:0] UNIT_SCALE  = 16'd65280;
   localparam logic [23:0] HALF_SCALE  = 24'd32640;
   localparam logic [12:0] RECIP_15    = 13'd4369;
   localparam logic [7:0]  LEVEL_MAX   = 8'd255;
   localparam int unsigned STAGES      = 6;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

   typedef struct packed {
      logic mul_en;
      logic div_en;
   } scale_ctl_type;

endpackage

[hw/rtl/hsv_to_rgb_converter.sv]
// hsv to rgb pixel converter, six-stage pipeline
//
//  channel   direction  fields                              handshake
//  req_      in         hue[12:0] saturation[7:0] brightness[7:0]  valid/stall
//  rsp_      out        red[7:0] green[7:0] blue[7:0]       valid/stall
//
// one pixel per clock sustained while rsp_stall is low; an accepted pixel raises rsp_valid after passing every stage
// stages: sector split, fraction, shade terms, multiply, divide, sector mux
// synchronous reset empties the pipeline, payload registers are not reset
// each stage holds while the one after it is full and stalled, so bubbles fill
// req_stall rises only when every stage is full and rsp_stall is high
module hsv_to_rgb_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [12:0] req_hue,
   input  logic [7:0]  req_saturation,
   input  logic [7:0]  req_brightness,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);

   logic [hsv2rgb_pkg::STAGES-1:0] vld_ff;
   logic [hsv2rgb_pkg::STAGES-1:0] vld_in;
   logic [hsv2rgb_pkg::STAGES-1:0] adv;

   // stage 1
   hsv2rgb_pkg::sector_type sec1_ff, sec1_in;
   logic [9:0]  rem1_ff, rem1_in;
   logic [7:0]  sat1_ff, val1_ff;
   logic [12:0] rem_wide;
   // stage 2
   hsv2rgb_pkg::sector_type sec2_ff;
   logic [7:0]  f8_2_ff, f8_2_in, sat2_ff, val2_ff;
   logic [24:0] f8_prod;
   // stage 3
   hsv2rgb_pkg::sector_type sec3_ff;
   logic [7:0]  val3_ff;
   logic [15:0] xp3_ff, xp3_in, xq3_ff, xq3_in, xt3_ff, xt3_in;
   logic [8:0]  f8_comp;
   // stages 4 and 5
   hsv2rgb_pkg::sector_type sec4_ff, sec5_ff;
   logic [7:0]  val4_ff, val5_ff;
   logic [7:0]  lvl_p, lvl_q, lvl_t;
   hsv2rgb_pkg::scale_ctl_type scale_ctl;
   // stage 6
   logic [7:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   always_comb begin
      adv[hsv2rgb_pkg::STAGES-1] = !vld_ff[hsv2rgb_pkg::STAGES-1] || !rsp_stall;
      for (int i = hsv2rgb_pkg::STAGES - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (adv[0]) begin
         vld_in[0] = req_valid;
      end
      for (int i = 1; i < hsv2rgb_pkg::STAGES; i++) begin
         if (adv[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !adv[0];

   // clamp and split hue into sector and remainder
   always_comb begin
      rem_wide = '0;
      sec1_in  = hsv2rgb_pkg::SECTOR_RED_YELLOW;
      priority if (req_hue >= hsv2rgb_pkg::HUE_LIMIT) begin
         rem_wide = '0;
         sec1_in  = hsv2rgb_pkg::SECTOR_RED_YELLOW;
      end else if (req_hue >= 13'(5 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         rem_wide = req_hue - 13'(5 * hsv2rgb_pkg::SECTOR_SPAN);
         sec1_in  = hsv2rgb_pkg::SECTOR_MAGENTA_RED;
      end else if (req_hue >= 13'(4 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         rem_wide = req_hue - 13'(4 * hsv2rgb_pkg::SECTOR_SPAN);
         sec1_in  = hsv2rgb_pkg::SECTOR_BLUE_MAGENTA;
      end else if (req_hue >= 13'(3 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         rem_wide = req_hue - 13'(3 * hsv2rgb_pkg::SECTOR_SPAN);
         sec1_in  = hsv2rgb_pkg::SECTOR_CYAN_BLUE;
      end else if (req_hue >= 13'(2 * hsv2rgb_pkg::SECTOR_SPAN)) begin
         rem_wide = req_hue - 13'(2 * hsv2rgb_pkg::SECTOR_SPAN);
         sec1_in  = hsv2rgb_pkg::SECTOR_GREEN_CYAN;
      end else if (req_hue >= hsv2rgb_pkg::SECTOR_SPAN) begin
         rem_wide = req_hue - hsv2rgb_pkg::SECTOR_SPAN;
         sec1_in  = hsv2rgb_pkg::SECTOR_YELLOW_GREEN;
      end else begin
         rem_wide = req_hue;
         sec1_in  = hsv2rgb_pkg::SECTOR_RED_YELLOW;
      end
   end

   assign rem1_in = rem_wide[9:0];

   // f8 = floor(rem * 4 / 15) via reciprocal of 15
   assign f8_prod = {13'd0, rem1_ff, 2'b01} * {12'd0, hsv2rgb_pkg::RECIP_15};
   assign f8_2_in = f8_prod[23:16];

   assign f8_comp = 9'd256 - {1'b0, f8_2_ff};
   assign xp3_in  = hsv2rgb_pkg::UNIT_SCALE - {sat2_ff, 8'd0};
   assign xq3_in  = hsv2rgb_pkg::UNIT_SCALE - ({8'd0, f8_2_ff} * {8'd0, sat2_ff});
   assign xt3_in  = hsv2rgb_pkg::UNIT_SCALE - ({7'd0, f8_comp} * {8'd0, sat2_ff});

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sec1_ff <= sec1_in;
         rem1_ff <= rem1_in;
         sat1_ff <= req_saturation;
         val1_ff <= req_brightness;
      end
      if (adv[1]) begin
         sec2_ff <= sec1_ff;
         f8_2_ff <= f8_2_in;
         sat2_ff <= sat1_ff;
         val2_ff <= val1_ff;
      end
      if (adv[2]) begin
         sec3_ff <= sec2_ff;
         val3_ff <= val2_ff;
         xp3_ff  <= xp3_in;
         xq3_ff  <= xq3_in;
         xt3_ff  <= xt3_in;
      end
      if (adv[3]) begin
         sec4_ff <= sec3_ff;
         val4_ff <= val3_ff;
      end
      if (adv[4]) begin
         sec5_ff <= sec4_ff;
         val5_ff <= val4_ff;
      end
      if (adv[5]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign scale_ctl.mul_en = adv[3];
   assign scale_ctl.div_en = adv[4];

   hsv2rgb_scale u_scale_p (
      .clock (clock),
      .v     (val3_ff),
      .x     (xp3_ff),
      .ctl   (scale_ctl),
      .level (lvl_p)
   );

   hsv2rgb_scale u_scale_q (
      .clock (clock),
      .v     (val3_ff),
      .x     (xq3_ff),
      .ctl   (scale_ctl),
      .level (lvl_q)
   );

   hsv2rgb_scale u_scale_t (
      .clock (clock),
      .v     (val3_ff),
      .x     (xt3_ff),
      .ctl   (scale_ctl),
      .level (lvl_t)
   );

   always_comb begin
      unique case (sec5_ff)
         hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
            red_in = val5_ff; green_in = lvl_t; blue_in = lvl_p;
         end
         hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
            red_in = lvl_q; green_in = val5_ff; blue_in = lvl_p;
         end
         hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
            red_in = lvl_p; green_in = val5_ff; blue_in = lvl_t;
         end
         hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
            red_in = lvl_p; green_in = lvl_q; blue_in = val5_ff;
         end
         hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
            red_in = lvl_t; green_in = lvl_p; blue_in = val5_ff;
         end
         default: begin
            red_in = val5_ff; green_in = lvl_p; blue_in = lvl_q;
         end
      endcase
   end

   assign rsp_valid = vld_ff[hsv2rgb_pkg::STAGES-1];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // accepted transaction lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted transaction missing from first stage");

   // input is held off only when the whole pipeline is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff) && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // occupancy grows by at most one transaction per cycle
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> $countones(vld_ff) <= $past($countones(vld_ff)) + 1)
      else $error("pipeline occupancy grew by more than one");

   // a stalled output stage keeps its neighbor from overwriting it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(red_ff) && $stable(blue_ff))
      else $error("stalled output stage was overwritten");

endmodule

[hw/rtl/hsv2rgb_scale.sv]
// two-stage level scaler: round(v * x / 65280)
module hsv2rgb_scale (
   input  logic                       clock,
   input  logic [7:0]                 v,
   input  logic [15:0]                x,
   input  hsv2rgb_pkg::scale_ctl_type ctl,
   output logic [7:0]                 level
);

   logic [23:0] prod_ff;
   logic [23:0] prod_in;
   logic [7:0]  level_ff;
   logic [7:0]  level_in;
   logic [15:0] z;
   logic [7:0]  q0;
   logic [8:0]  r;

   assign prod_in = {16'd0, v} * {8'd0, x} + hsv2rgb_pkg::HALF_SCALE;

   // divide by 255 * 256: drop low byte, then divide by 255 with one correction
   assign z  = prod_ff[23:8];
   assign q0 = z[15:8];
   assign r  = {1'b0, z[7:0]} + {1'b0, q0};

   always_comb begin
      if (r >= {1'b0, hsv2rgb_pkg::LEVEL_MAX}) begin
         level_in = q0 + 8'd1;
      end else begin
         level_in = q0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.div_en) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

[tb/sv/hsv_pixel_checker.sv]
// checker for the hsv to rgb converter: predicts each pixel and compares the rgb results
module hsv_pixel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [12:0] req_hue,
   input  logic [7:0]  req_saturation,
   input  logic [7:0]  req_brightness,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count
);

   localparam int TRACK_DEPTH = 16;

   typedef struct packed {
      logic [12:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } pixel_record_type;

   pixel_record_type pending_pixels [TRACK_DEPTH];
   pixel_record_type oldest_pixel;
   logic [3:0]       read_index = '0;
   logic [3:0]       write_index = '0;
   int               pending_total = 0;
   int               mismatch_total = 0;
   int               checked_total = 0;

   function automatic logic [7:0] shade_level(input int unsigned level,
                                              input int unsigned scale);
      int unsigned rounded;
      rounded = (level * scale + hsv2rgb_pkg::HALF_SCALE) / hsv2rgb_pkg::UNIT_SCALE;
      return rounded[7:0];
   endfunction

   function automatic pixel_record_type convert_pixel(input logic [12:0] hue,
                                                      input logic [7:0] saturation,
                                                      input logic [7:0] brightness);
      pixel_record_type        pixel;
      int unsigned             clamped_hue;
      int unsigned             quotient;
      int unsigned             remainder;
      int unsigned             fraction;
      int unsigned             sat;
      int unsigned             val;
      logic [7:0]              level_p;
      logic [7:0]              level_q;
      logic [7:0]              level_t;
      hsv2rgb_pkg::sector_type sector;
      sat = saturation;
      val = brightness;
      clamped_hue = (hue > hsv2rgb_pkg::HUE_LIMIT) ? hsv2rgb_pkg::HUE_LIMIT : hue;
      quotient = clamped_hue / hsv2rgb_pkg::SECTOR_SPAN;
      remainder = clamped_hue - quotient * hsv2rgb_pkg::SECTOR_SPAN;
      sector = hsv2rgb_pkg::sector_type'(quotient % 6);
      fraction = (remainder * 256) / hsv2rgb_pkg::SECTOR_SPAN;
      level_p = shade_level(val, hsv2rgb_pkg::UNIT_SCALE - 256 * sat);
      level_q = shade_level(val, hsv2rgb_pkg::UNIT_SCALE - fraction * sat);
      level_t = shade_level(val, hsv2rgb_pkg::UNIT_SCALE - (256 - fraction) * sat);
      pixel.hue = hue;
      pixel.saturation = saturation;
      pixel.brightness = brightness;
      case (sector)
         hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
            pixel.red = brightness; pixel.green = level_t; pixel.blue = level_p;
         end
         hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
            pixel.red = level_q; pixel.green = brightness; pixel.blue = level_p;
         end
         hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
            pixel.red = level_p; pixel.green = brightness; pixel.blue = level_t;
         end
         hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
            pixel.red = level_p; pixel.green = level_q; pixel.blue = brightness;
         end
         hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
            pixel.red = level_t; pixel.green = level_p; pixel.blue = brightness;
         end
         default: begin
            pixel.red = brightness; pixel.green = level_p; pixel.blue = level_q;
         end
      endcase
      return pixel;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         read_index = '0;
         write_index = '0;
         pending_total = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_total == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("mismatch: unexpected result %0d/%0d/%0d",
                           rsp_red, rsp_green, rsp_blue);
            end else begin
               oldest_pixel = pending_pixels[read_index];
               read_index = read_index + 4'd1;
               pending_total--;
               checked_total++;
               if (rsp_red !== oldest_pixel.red || rsp_green !== oldest_pixel.green ||
                   rsp_blue !== oldest_pixel.blue) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display({"mismatch: hue %0d sat %0d val %0d",
                               " expected %0d/%0d/%0d got %0d/%0d/%0d"},
                              oldest_pixel.hue, oldest_pixel.saturation,
                              oldest_pixel.brightness, oldest_pixel.red,
                              oldest_pixel.green, oldest_pixel.blue,
                              rsp_red, rsp_green, rsp_blue);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (pending_total == TRACK_DEPTH) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("mismatch: more than %0d transactions in flight", TRACK_DEPTH);
            end else begin
               pending_pixels[write_index] = convert_pixel(req_hue, req_saturation,
                                                           req_brightness);
               write_index = write_index + 4'd1;
               pending_total++;
            end
         end
      end
      mismatch_count <= mismatch_total;
      pending_count <= pending_total;
      checked_count <= checked_total;
   end

endmodule

[tb/sv/hsv_to_rgb_converter_tb.sv]
// testbench top for the hsv to rgb converter: stimulus, receiver stalls and verdict
module hsv_to_rgb_converter_tb;

   localparam int RANDOM_PIXELS  = 1032;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 60;
   localparam int HOLD_TRIGGER   = 300;
   localparam int DRAIN_CYCLES   = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [12:0] req_hue = '0;
   logic [7:0]  req_saturation = '0;
   logic [7:0]  req_brightness = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int pixels_sent = 0;
   int idle_cycles = 0;
   bit hold_done = 1'b0;

   hsv_to_rgb_converter DUT (.*);

   hsv_pixel_checker pixel_checker (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_valid && !req_stall)
            pixels_sent <= pixels_sent + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // receiver stall pattern, with one long hold-off to back up the pipeline
   initial begin : receiver
      int mode;
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && pixels_sent >= HOLD_TRIGGER) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            repeat (span) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 1) == 1);
                  default: rsp_stall <= ($urandom_range(0, 5) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_pixel(input logic [12:0] hue, input logic [7:0] sat,
                             input logic [7:0] val);
      req_valid <= 1'b1;
      req_hue <= hue;
      req_saturation <= sat;
      req_brightness <= val;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_pixel();
      logic [12:0] hue;
      case ($urandom_range(0, 9))
         0: hue = 13'($urandom_range(5761, 8191));
         1: hue = 13'($urandom_range(1, 6) * 960 - $urandom_range(0, 2));
         default: hue = 13'($urandom_range(0, 5760));
      endcase
      send_pixel(hue, random_channel(), random_channel());
   endtask

   initial begin : stimulus
      int burst;
      int random_sent;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // primaries and sector starts at full saturation and value
      send_pixel(13'd0,    8'd255, 8'd255);
      send_pixel(13'd960,  8'd255, 8'd255);
      send_pixel(13'd1920, 8'd255, 8'd255);
      send_pixel(13'd2880, 8'd255, 8'd255);
      send_pixel(13'd3840, 8'd255, 8'd255);
      send_pixel(13'd4800, 8'd255, 8'd255);
      // full circle and clamp above range
      send_pixel(13'd5760, 8'd200, 8'd180);
      send_pixel(13'd5761, 8'd200, 8'd180);
      send_pixel(13'd8191, 8'd255, 8'd255);
      // last hue of a sector
      send_pixel(13'd959,  8'd255, 8'd255);
      send_pixel(13'd1919, 8'd128, 8'd200);
      send_pixel(13'd5759, 8'd255, 8'd128);
      // gray and black
      send_pixel(13'd3000, 8'd0,   8'd173);
      send_pixel(13'd8191, 8'd0,   8'd255);
      send_pixel(13'd1234, 8'd255, 8'd0);
      send_pixel(13'd0,    8'd0,   8'd0);
      // mid sector shading
      send_pixel(13'd480,  8'd128, 8'd200);
      send_pixel(13'd1,    8'd255, 8'd255);
      send_pixel(13'd4321, 8'd1,   8'd254);
      send_pixel(13'd2400, 8'd170, 8'd85);
      send_pixel(13'd3361, 8'd254, 8'd1);

      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
         repeat (burst) begin
            if (random_sent < RANDOM_PIXELS) begin
               send_random_pixel();
               random_sent++;
            end
         end
         if ($urandom_range(0, 2) != 0)
            pause_sender($urandom_range(1, 8));
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d pixels: all six sectors, sector edges, hue wrap and clamp,",
               pixels_sent);
      $display("gray and black pixels, %0d results checked under random and long stalls",
               checked_count);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
